@@ hw/rtl/mbps_pkg.sv @@
// Shared widths, register indexes and reset values for the masked byte pattern scanner.
package mbps_pkg;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned SIZE_W      = 29;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned MASK_W      = 16;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CAP_W       = 33;

  // The pattern registers hold sixteen bytes at most.
  localparam int unsigned PATTERN_REG_BYTES = 16;

  localparam int unsigned        MAX_PATTERN_BYTES_DEF = 16;
  localparam logic [CAP_W-1:0]   REGION_SIZE_CAP_DEF   = 33'h0_1000_0000;

  localparam logic [SIZE_W-1:0]  REGION_SIZE_RST  = 29'd4096;
  localparam logic [LEN_W-1:0]   PATTERN_LEN_RST  = 5'd1;
  localparam logic [MASK_W-1:0]  EXACT_MASK_RST   = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS       = 3'd0,
    CFG_REGION_SIZE        = 3'd1,
    CFG_PATTERN_LENGTH     = 3'd2,
    CFG_PATTERN_LOW_BYTES  = 3'd3,
    CFG_PATTERN_HIGH_BYTES = 3'd4,
    CFG_EXACT_BYTE_MASK    = 3'd5
  } cfg_reg_t;

endpackage

@@ hw/rtl/mbps_ifs.sv @@
// Valid/ready channel interfaces for the scanner's input, result and configuration words.
interface mbps_in_if;
  import mbps_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              readable;
  modport source (output valid, data_byte, readable, input ready);
  modport sink   (input valid, data_byte, readable, output ready);
endinterface

interface mbps_out_if;
  import mbps_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] match_address;
  logic              found;
  modport source (output valid, match_address, found, input ready);
  modport sink   (input valid, match_address, found, output ready);
endinterface

interface mbps_cfg_if;
  import mbps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] write_data;
  modport source (output valid, reg_index, write_data, input ready);
  modport sink   (input valid, reg_index, write_data, output ready);
endinterface

@@ hw/rtl/masked_byte_pattern_scan.sv @@
// Top level of the wildcard masked byte pattern scanner.
//
// The scanner takes a memory region one byte word per cycle, in address order, each word
// flagged readable or not, and reports the first place where the programmed pattern of up
// to sixteen bytes matches. Pattern bytes whose bit in exact_byte_mask is clear match any
// value. An unreadable byte breaks the current run, so no match can span it, but it still
// counts toward the region size. On a match the block emits one result word with found set
// and the address base_address plus the offset of the match start; if the region ends
// without a match it emits found clear and a zero address. Either way the scan restarts
// for the next region. Each byte is compared while it sits in the input register and its
// result is loaded into the output register as the byte leaves that register, and a new byte
// is accepted every cycle while the compare stage is not stalled: all window positions are
// compared in parallel against the history registers, and the run and byte counters update
// in the same cycle. The compare stage stalls only when it has a result and the output
// register still holds an untaken one. Configuration is written through its own channel,
// always ready, and must only be written while no byte is in flight.
module masked_byte_pattern_scan #(
  parameter int unsigned                  MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
  parameter logic [mbps_pkg::CAP_W-1:0]   REGION_SIZE_CAP   = mbps_pkg::REGION_SIZE_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mbps_cfg_if.sink    cfg,
  mbps_in_if.sink     scan_in,
  mbps_out_if.source  scan_out
);
  import mbps_pkg::*;

  // Window depth actually used: the pattern registers cap it at sixteen bytes.
  localparam int unsigned PAT_LIMIT =
    (MAX_PATTERN_BYTES < PATTERN_REG_BYTES) ? MAX_PATTERN_BYTES : PATTERN_REG_BYTES;
  localparam logic [LEN_W-1:0] PAT_LIMIT_L = LEN_W'(PAT_LIMIT);

  // Configuration registers.
  logic [ADDR_W-1:0] base_address;
  logic [SIZE_W-1:0] region_size;
  logic [LEN_W-1:0]  pattern_length;
  logic [63:0]       pattern_low_bytes;
  logic [63:0]       pattern_high_bytes;
  logic [MASK_W-1:0] exact_byte_mask;

  // Input register.
  logic              s1_valid;
  logic [DATA_W-1:0] s1_byte;
  logic              s1_readable;

  // Scan state. The history holds the newest readable bytes; only bytes of the current
  // readable run are ever compared, so it needs no reset.
  logic [DATA_W-1:0] history [PAT_LIMIT];
  logic [LEN_W-1:0]  run_len;
  logic [SIZE_W-1:0] bytes_consumed;

  // Output register.
  logic              out_valid;
  logic [ADDR_W-1:0] out_address;
  logic              out_found;

  // Compare stage signals.
  logic [DATA_W-1:0]   history_next [PAT_LIMIT];
  logic [LEN_W-1:0]    run_len_next;
  logic [SIZE_W-1:0]   bytes_consumed_next;
  logic [LEN_W-1:0]    len_eff;
  logic [SIZE_W-1:0]   size_eff;
  logic [PAT_LIMIT-1:0] slot_ok;
  logic [127:0]        pattern_all;
  logic                match_hit;
  logic                region_end;
  logic                produce;
  logic                s1_fire;
  logic [ADDR_W-1:0]   hit_address;

  // The size register can never exceed the cap when the cap is above its range.
  always_comb begin
    if ({{(CAP_W-SIZE_W){1'b0}}, region_size} > REGION_SIZE_CAP) begin
      size_eff = REGION_SIZE_CAP[SIZE_W-1:0];
    end else if (region_size == '0) begin
      size_eff = SIZE_W'(1);
    end else begin
      size_eff = region_size;
    end
    len_eff = (pattern_length > PAT_LIMIT_L) ? PAT_LIMIT_L : pattern_length;
  end

  // Each window slot j (0 is the newest byte) lines up with pattern byte len-1-j.
  always_comb begin
    logic [LEN_W-1:0] pidx;
    pattern_all = {pattern_high_bytes, pattern_low_bytes};
    history_next[0] = s1_byte;
    for (int j = 1; j < PAT_LIMIT; j++) begin
      history_next[j] = history[j-1];
    end
    for (int j = 0; j < PAT_LIMIT; j++) begin
      pidx = len_eff - LEN_W'(1) - LEN_W'(j);
      if (LEN_W'(j) >= len_eff || !exact_byte_mask[pidx[3:0]]) begin
        slot_ok[j] = 1'b1;
      end else begin
        slot_ok[j] = (history_next[j] == pattern_all[{pidx[3:0], 3'b000} +: DATA_W]);
      end
    end

    if (!s1_readable) begin
      run_len_next = '0;
    end else if (run_len < PAT_LIMIT_L) begin
      run_len_next = run_len + LEN_W'(1);
    end else begin
      run_len_next = run_len;
    end

    bytes_consumed_next = bytes_consumed + SIZE_W'(1);
    match_hit  = s1_readable && (len_eff != '0) && (run_len_next >= len_eff) && (&slot_ok);
    region_end = (bytes_consumed_next >= size_eff);
    produce    = match_hit || region_end;
    hit_address = base_address +
                  ADDR_W'(bytes_consumed_next - {{(SIZE_W-LEN_W){1'b0}}, len_eff});
  end

  // A byte with no result never waits; one with a result waits for a free output register.
  assign s1_fire       = s1_valid && (!produce || !out_valid || scan_out.ready);
  assign scan_in.ready = !s1_valid || s1_fire;
  assign cfg.ready     = 1'b1;

  assign scan_out.valid         = out_valid;
  assign scan_out.match_address = out_address;
  assign scan_out.found         = out_found;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address       <= '0;
      region_size        <= REGION_SIZE_RST;
      pattern_length     <= PATTERN_LEN_RST;
      pattern_low_bytes  <= '0;
      pattern_high_bytes <= '0;
      exact_byte_mask    <= EXACT_MASK_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.reg_index))
        CFG_BASE_ADDRESS:       base_address       <= cfg.write_data;
        CFG_REGION_SIZE:        region_size        <= cfg.write_data[SIZE_W-1:0];
        CFG_PATTERN_LENGTH:     pattern_length     <= cfg.write_data[LEN_W-1:0];
        CFG_PATTERN_LOW_BYTES:  pattern_low_bytes  <= cfg.write_data;
        CFG_PATTERN_HIGH_BYTES: pattern_high_bytes <= cfg.write_data;
        CFG_EXACT_BYTE_MASK:    exact_byte_mask    <= cfg.write_data[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan_in.valid && scan_in.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
    if (scan_in.valid && scan_in.ready) begin
      s1_byte     <= scan_in.data_byte;
      s1_readable <= scan_in.readable;
    end
  end

  // History shifts only on readable bytes.
  always_ff @(posedge clk) begin
    if (s1_fire && s1_readable) begin
      history <= history_next;
    end
  end

  // Run and byte counters; both restart after every result.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_len        <= '0;
      bytes_consumed <= '0;
    end else if (s1_fire) begin
      run_len        <= produce ? '0 : run_len_next;
      bytes_consumed <= produce ? '0 : bytes_consumed_next;
    end
  end

  // Output register. A match takes precedence over the end of the region.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && produce) begin
      out_valid <= 1'b1;
    end else if (scan_out.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && produce) begin
      out_found   <= match_hit;
      out_address <= match_hit ? hit_address : '0;
    end
  end

  // The run count never passes the window depth.
  assert property (@(posedge clk) disable iff (rst) run_len <= PAT_LIMIT_L)
    else $error("run length above window depth");

  // Every result restarts the scan.
  assert property (@(posedge clk) disable iff (rst)
    (s1_fire && produce) |=> (run_len == '0 && bytes_consumed == '0))
    else $error("scan state not cleared after a result");

  // A byte held in the compare stage means the output register is full and stalled.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |-> (out_valid && !scan_out.ready))
    else $error("compare stage stalled without a blocked result");

  // A region that ends without a match reports a zero address.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> (out_address == '0))
    else $error("nonzero address on a result without a match");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the masked byte pattern scanner.
module tb_top;
  import mbps_pkg::*;

  // Longest pattern the scanner can hold: the smaller of its parameter and the register width.
  localparam int unsigned PAT_LIMIT = (MAX_PATTERN_BYTES_DEF < PATTERN_REG_BYTES) ?
                                      MAX_PATTERN_BYTES_DEF : PATTERN_REG_BYTES;
  // Register indexes past the defined set; a write to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  // A byte passes the input register and then the output register; these spare cycles
  // are enough for any byte still in the pipe after the last expected report has come out.
  localparam int SETTLE_CYCLES  = 6;
  localparam int RANDOM_WORDS   = 1500;
  localparam int BURST_WORDS    = 250;
  localparam int TIMEOUT_UNITS  = 1_000_000;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              found;
  } scan_report_t;

  logic clk;
  logic rst;

  mbps_cfg_if cfg_ch ();
  mbps_in_if  in_ch ();
  mbps_out_if out_ch ();

  masked_byte_pattern_scan u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_ch),
    .scan_in  (in_ch),
    .scan_out (out_ch)
  );

  // Shadow copy of the configuration registers, updated on every accepted write.
  logic [ADDR_W-1:0]     cur_base;
  logic [SIZE_W-1:0]     cur_size;
  logic [LEN_W-1:0]      cur_len;
  logic [2*ADDR_W-1:0]   cur_pattern;
  logic [MASK_W-1:0]     cur_mask;

  // Shadow copy of the scan state: newest byte in entry 0.
  logic [DATA_W-1:0]     hist_bytes [PATTERN_REG_BYTES];
  int unsigned           run_len;
  logic [63:0]           consumed;

  // Reports the scanner owes us, oldest first.
  scan_report_t          awaited_reports [$];
  scan_report_t          seen_report;

  bit                    idle_enable;
  int                    out_stall_left = 0;
  int                    mismatch_count = 0;
  int                    words_sent;
  int                    hit_count = 0;
  int                    end_count = 0;
  int                    setup_count;

  always #1 clk = ~clk;

  // The run is bounded no matter what the scanner does.
  initial begin
    #(TIMEOUT_UNITS);
    $display("Timeout with %0d reports outstanding", awaited_reports.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ------------------------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------------------------

  // Pattern length as the scanner uses it: anything past the hardware limit saturates.
  function automatic int unsigned pattern_span();
    int unsigned n;
    n = cur_len;
    if (n > PAT_LIMIT) n = PAT_LIMIT;
    return n;
  endfunction

  // Every scan state goes back to its reset value after a report.
  function automatic void restart_region();
    int i;
    for (i = 0; i < PATTERN_REG_BYTES; i++) hist_bytes[i] = '0;
    run_len  = 0;
    consumed = '0;
  endfunction

  // The window ends at the newest byte; pattern byte 0 lines up with the oldest byte of
  // the window. Pattern bytes with a clear mask bit accept anything.
  function automatic bit window_hits(input int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      if (cur_mask[i] && hist_bytes[len - 1 - i] != cur_pattern[i*8 +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advances the shadow scan by one accepted byte and queues any report it causes.
  function automatic void advance_scan(input logic [DATA_W-1:0] b, input logic rd);
    logic [63:0]  eff_size;
    int unsigned  eff_len;
    int           i;
    scan_report_t rep;
    eff_size = 64'(cur_size);
    if (eff_size > 64'(REGION_SIZE_CAP_DEF)) eff_size = 64'(REGION_SIZE_CAP_DEF);
    if (eff_size == 0) eff_size = 1;
    eff_len  = pattern_span();
    consumed = consumed + 1;
    if (rd) begin
      for (i = PATTERN_REG_BYTES - 1; i > 0; i--) hist_bytes[i] = hist_bytes[i-1];
      hist_bytes[0] = b;
      if (run_len < PAT_LIMIT) run_len++;
      // A match on the last byte of the region wins over the end of the region.
      if (eff_len > 0 && run_len >= eff_len && window_hits(eff_len)) begin
        rep.address = cur_base + consumed - 64'(eff_len);
        rep.found   = 1'b1;
        awaited_reports.push_back(rep);
        restart_region();
        return;
      end
    end else begin
      // An unreadable byte breaks the run but still counts toward the region size.
      for (i = 0; i < PATTERN_REG_BYTES; i++) hist_bytes[i] = '0;
      run_len = 0;
    end
    if (consumed >= eff_size) begin
      rep.address = '0;
      rep.found   = 1'b0;
      awaited_reports.push_back(rep);
      restart_region();
    end
  endfunction

  // ------------------------------------------------------------------------------------------
  // Channel handling
  // ------------------------------------------------------------------------------------------

  // The result side stalls in random bursts while idling is enabled; otherwise it is ready
  // once any burst under way has run out. Its ready changes only at the falling edge.
  always @(negedge clk) begin
    if (out_stall_left > 0) begin
      out_ch.ready   = 1'b0;
      out_stall_left = out_stall_left - 1;
    end else if (idle_enable && $urandom_range(0, 7) == 0) begin
      out_ch.ready   = 1'b0;
      out_stall_left = $urandom_range(1, 6) - 1;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Every report taken is compared against the oldest one still owed.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (awaited_reports.size() == 0) begin
        $error("unexpected report: match_address %h found %b", out_ch.match_address,
               out_ch.found);
        mismatch_count++;
      end else begin
        seen_report = awaited_reports.pop_front();
        if (out_ch.found !== seen_report.found) begin
          $error("found: expected %b, got %b", seen_report.found, out_ch.found);
          mismatch_count++;
        end
        if (out_ch.match_address !== seen_report.address) begin
          $error("match_address: expected %h, got %h", seen_report.address,
                 out_ch.match_address);
          mismatch_count++;
        end
        if (seen_report.found) hit_count++;
        else end_count++;
      end
    end
  end

  // Offers one byte word and holds it until the scanner takes it. Called and returns at a
  // falling edge; the valid is left high so back-to-back words need no idle gap between them.
  task automatic send_byte(input logic [DATA_W-1:0] b, input logic rd);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.data_byte = b;
    in_ch.readable  = rd;
    do @(posedge clk); while (!in_ch.ready);
    advance_scan(b, rd);
    words_sent++;
    @(negedge clk);
  endtask

  // Waits for every owed report, then lets the pipe run empty. Only after this is a
  // register write safe.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes one register and mirrors it into the shadow copy.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid      = 1'b1;
    cfg_ch.reg_index  = idx;
    cfg_ch.write_data = val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_BASE_ADDRESS:       cur_base                   = val;
      CFG_REGION_SIZE:        cur_size                   = val[SIZE_W-1:0];
      CFG_PATTERN_LENGTH:     cur_len                    = val[LEN_W-1:0];
      CFG_PATTERN_LOW_BYTES:  cur_pattern[ADDR_W-1:0]    = val;
      CFG_PATTERN_HIGH_BYTES: cur_pattern[2*ADDR_W-1:ADDR_W] = val;
      CFG_EXACT_BYTE_MASK:    cur_mask                   = val[MASK_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // ------------------------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------------------------

  // Reset values: a one-byte pattern of 0x00, exact, at base 0. A zero byte matches at
  // once; after a 0xFF the next zero matches at offset 1 of the new region.
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    settle();
  endtask

  // The longest pattern, all wildcards, with a length write above the maximum and a region
  // size past the cap. An unreadable byte first pushes the match to offset 1, which wraps
  // the address from the top of the address space to zero.
  task automatic test_wildcard_full_length();
    int i;
    write_reg(CFG_BASE_ADDRESS, '1);
    write_reg(CFG_REGION_SIZE, 64'h0000_0000_1FFF_FFFF);
    write_reg(CFG_PATTERN_LENGTH, 64'd31);
    write_reg(CFG_PATTERN_HIGH_BYTES, {$urandom, $urandom});
    write_reg(CFG_EXACT_BYTE_MASK, 64'h0);
    send_byte(8'hFF, 1'b0);
    for (i = 0; i < PAT_LIMIT; i++) send_byte(8'($urandom), 1'b1);
    settle();
  endtask

  // Region edges: a zero length never matches and a zero size acts as one byte, so a
  // single byte closes the region empty. Then a two-byte exact pattern that completes on
  // the last byte of a three-byte region gives a hit and no separate end report.
  task automatic test_region_edges();
    write_reg(CFG_BASE_ADDRESS, 64'h0000_0000_0000_1000);
    write_reg(CFG_PATTERN_LENGTH, 64'd0);
    write_reg(CFG_REGION_SIZE, 64'd0);
    send_byte(8'hAB, 1'b1);
    settle();
    write_reg(CFG_PATTERN_LENGTH, 64'd2);
    write_reg(CFG_PATTERN_LOW_BYTES, 64'h0000_0000_0000_CDAB);
    write_reg(CFG_EXACT_BYTE_MASK, 64'hFFFF);
    write_reg(CFG_REGION_SIZE, 64'd3);
    send_byte(8'h00, 1'b1);
    send_byte(8'hAB, 1'b1);
    send_byte(8'hCD, 1'b1);
    settle();
  endtask

  // Picks a fresh setting. Each register is rewritten most of the time; values lean toward
  // small regions and short patterns so that reports come often, with the extremes and
  // junk in the unused upper bits mixed in.
  task automatic random_setup();
    logic [CFG_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_BASE_ADDRESS, '0);
        1:       write_reg(CFG_BASE_ADDRESS, '1);
        2:       write_reg(CFG_BASE_ADDRESS, {32'hFFFF_FFFF, $urandom});
        default: write_reg(CFG_BASE_ADDRESS, {$urandom, $urandom});
      endcase
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 11))
        0:       write_reg(CFG_REGION_SIZE, junk & ~64'h1FFF_FFFF);
        1:       write_reg(CFG_REGION_SIZE, 64'h1FFF_FFFF);
        2:       write_reg(CFG_REGION_SIZE, 64'(REGION_SIZE_CAP_DEF) + $urandom_range(0, 9));
        3:       write_reg(CFG_REGION_SIZE,
                           (junk & ~64'h1FFF_FFFF) | 64'($urandom_range(1, 64)));
        default: write_reg(CFG_REGION_SIZE, 64'($urandom_range(1, 48)));
      endcase
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 11))
        0:       write_reg(CFG_PATTERN_LENGTH, 64'd0);
        1:       write_reg(CFG_PATTERN_LENGTH, 64'($urandom_range(17, 31)));
        2:       write_reg(CFG_PATTERN_LENGTH, 64'(PAT_LIMIT));
        3:       write_reg(CFG_PATTERN_LENGTH,
                           (junk & ~64'h1F) | 64'($urandom_range(1, 4)));
        4, 5:    write_reg(CFG_PATTERN_LENGTH, 64'($urandom_range(7, 16)));
        default: write_reg(CFG_PATTERN_LENGTH, 64'($urandom_range(1, 6)));
      endcase
    end
    if ($urandom_range(0, 3) != 0) write_reg(CFG_PATTERN_LOW_BYTES, {$urandom, $urandom});
    if ($urandom_range(0, 3) != 0) write_reg(CFG_PATTERN_HIGH_BYTES, {$urandom, $urandom});
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_EXACT_BYTE_MASK, 64'hFFFF);
        1:       write_reg(CFG_EXACT_BYTE_MASK, junk & ~64'hFFFF);
        default: write_reg(CFG_EXACT_BYTE_MASK, junk);
      endcase
    end
    // Indexes past the register set are written now and then; nothing may change.
    if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE_A, junk);
    if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE_B, ~junk);
    setup_count++;
  endtask

  // Streams about the given number of words under the current setting. Most of the stream
  // plants copies of the pattern (wildcard positions filled with noise), some of them
  // broken by a wrong or unreadable byte; the rest is plain noise and bytes drawn from the
  // pattern, which make partial matches.
  task automatic stream_words(input int count);
    int          start;
    int unsigned plen;
    int unsigned i;
    int unsigned spoil_at;
    bit          spoil;
    logic [DATA_W-1:0] b;
    start = words_sent;
    plen  = pattern_span();
    while (words_sent - start < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          spoil    = ($urandom_range(0, 5) == 0);
          spoil_at = $urandom_range(0, (plen > 0) ? plen - 1 : 0);
          for (i = 0; i < plen; i++) begin
            b = cur_mask[i] ? cur_pattern[i*8 +: 8] : 8'($urandom);
            if (spoil && i == spoil_at) begin
              if ($urandom_range(0, 1)) send_byte(~b, 1'b1);
              else send_byte(b, 1'b0);
            end else begin
              send_byte(b, 1'b1);
            end
          end
          if (plen == 0) send_byte(8'($urandom), 1'b1);
        end
        4, 5, 6, 7: send_byte(8'($urandom), $urandom_range(0, 9) != 0);
        default: send_byte(cur_pattern[$urandom_range(0, PATTERN_REG_BYTES - 1)*8 +: 8], 1'b1);
      endcase
    end
    settle();
  endtask

  // Random settings and streams with idling on both sides.
  task automatic test_random_regions();
    int target;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      random_setup();
      stream_words($urandom_range(15, 60));
    end
  endtask

  // The closing stretch runs with no idling at all, so words and reports move every cycle.
  task automatic test_back_to_back();
    int target;
    idle_enable = 1'b0;
    target      = words_sent + BURST_WORDS;
    while (words_sent < target) begin
      random_setup();
      stream_words($urandom_range(30, 80));
    end
  endtask

  // ------------------------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------------------------

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.readable    = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.reg_index  = '0;
    cfg_ch.write_data = '0;
    idle_enable       = 1'b1;
    words_sent        = 0;
    setup_count       = 0;
    cur_base          = '0;
    cur_size          = REGION_SIZE_RST;
    cur_len           = PATTERN_LEN_RST;
    cur_pattern       = '0;
    cur_mask          = EXACT_MASK_RST;
    restart_region();

    repeat (6) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_wildcard_full_length();
    test_region_edges();
    test_random_regions();
    test_back_to_back();
    settle();

    $display("Scanned %0d byte words under %0d random settings plus the directed cases.",
             words_sent, setup_count);
    $display("Checked %0d pattern hits and %0d regions that ended without a match.",
             hit_count, end_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_ifs.sv
hw/rtl/masked_byte_pattern_scan.sv
dv/tb_top.sv
